>>> src/rtmp_cse_pkg.sv
// Shared types and constants for the chunk stream encoder.
package rtmp_cse_pkg;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_BODY  = 1'b1;
  localparam logic [31:0] TS_MAX  = 32'h00ffffff;
  localparam logic [9:0] ID_ONE_MAX = 10'd63;
  localparam logic [9:0] ID_TWO_MAX = 10'd319;
  localparam logic [9:0] ID_BASE    = 10'd64;

  localparam logic [1:0] FORM_0 = 2'd0;
  localparam logic [1:0] FORM_1 = 2'd1;
  localparam logic [1:0] FORM_2 = 2'd2;
  localparam logic [1:0] FORM_3 = 2'd3;

  // one channel record as kept in memory
  typedef struct packed {
    logic [31:0] stream_id;
    logic [7:0]  type_id;
    logic [23:0] size;
    logic [31:0] timestamp;
    logic [31:0] delta;
  } chan_rec_t;

  // header burst descriptor handed to the serializer
  typedef struct packed {
    logic [1:0]  form;
    logic [9:0]  csid;
    logic [31:0] tsf;
    logic [23:0] size;
    logic [7:0]  type_id;
    logic [31:0] stream_id;
    logic        ext;
    logic        body;       // a single body byte, possibly with continuation header
    logic        cont;       // continuation basic header before the body byte
    logic [7:0]  body_byte;
    logic        chunk_end;
    logic        message_end;
  } burst_t;

  function automatic logic [4:0] basic_len(input logic [9:0] id);
    if (id > ID_TWO_MAX) basic_len = 5'd3;
    else if (id > ID_ONE_MAX) basic_len = 5'd2;
    else basic_len = 5'd1;
  endfunction

endpackage

>>> src/rtmp_cse_ser.sv
// Burst serializer: turns one burst descriptor into output bytes.
module rtmp_cse_ser
  import rtmp_cse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  burst_t     in_burst,
  output logic       valid,
  input  logic       ready,
  output logic [7:0] out_byte,
  output logic       chunk_end,
  output logic       message_end,
  output logic       run_last
);

  burst_t     cur;
  logic       busy;
  logic [4:0] pos;
  logic [4:0] blen, n_ts, n_sz, n_sid, n_ext, total;
  logic [15:0] off;
  logic [23:0] t24;
  logic [4:0] p;
  logic [7:0] b;
  logic       is_body;
  logic       last;

  always_comb begin
    blen = basic_len(cur.csid);
    off  = {6'd0, cur.csid - ID_BASE};
    t24  = cur.ext ? TS_MAX[23:0] : cur.tsf[23:0];
    n_ts = 5'd0; n_sz = 5'd0; n_sid = 5'd0; n_ext = 5'd0;
    if (cur.body) begin
      total = (cur.cont ? blen : 5'd0) + 5'd1;
    end else begin
      if (cur.form != FORM_3) n_ts = 5'd3;
      if (cur.form == FORM_0 || cur.form == FORM_1) n_sz = 5'd4;
      if (cur.form == FORM_0) n_sid = 5'd4;
      if (cur.ext) n_ext = 5'd4;
      total = blen + n_ts + n_sz + n_sid + n_ext;
    end
    last = (pos == total - 5'd1);
    is_body = cur.body && last;
    b = 8'd0;
    p = pos;
    if (is_body) begin
      b = cur.body_byte;
    end else if (p < blen) begin
      case (p)
        5'd0: begin
          if (blen == 5'd1) b = {cur.form, cur.csid[5:0]};
          else b = {cur.form, 5'd0, blen == 5'd3};
        end
        5'd1: b = off[7:0];
        default: b = off[15:8];
      endcase
    end else begin
      p = pos - blen;
      if (p < n_ts) begin
        case (p[1:0])
          2'd0: b = t24[23:16];
          2'd1: b = t24[15:8];
          default: b = t24[7:0];
        endcase
      end else begin
        p = p - n_ts;
        if (p < n_sz) begin
          case (p[1:0])
            2'd0: b = cur.size[23:16];
            2'd1: b = cur.size[15:8];
            2'd2: b = cur.size[7:0];
            default: b = cur.type_id;
          endcase
        end else begin
          p = p - n_sz;
          if (p < n_sid) begin
            case (p[1:0])
              2'd0: b = cur.stream_id[7:0];
              2'd1: b = cur.stream_id[15:8];
              2'd2: b = cur.stream_id[23:16];
              default: b = cur.stream_id[31:24];
            endcase
          end else begin
            p = p - n_sid;
            case (p[1:0])
              2'd0: b = cur.tsf[31:24];
              2'd1: b = cur.tsf[23:16];
              2'd2: b = cur.tsf[15:8];
              default: b = cur.tsf[7:0];
            endcase
          end
        end
      end
    end
  end

  assign valid       = busy;
  assign out_byte    = b;
  assign chunk_end   = is_body & cur.chunk_end;
  assign message_end = is_body & cur.message_end;
  assign run_last    = last;
  assign in_ready    = !busy || (ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 5'd0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      pos  <= 5'd0;
    end else if (busy && ready) begin
      if (last) busy <= 1'b0;
      pos <= pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cur <= in_burst;
  end

endmodule

>>> src/rtmp_chunk_stream_encoder.sv
// Top level of the chunk stream encoder: channel memory, chunk tracking, serializer.
// A body item yields one byte (plus a 1-3 byte basic header at a chunk boundary);
// a start item yields a header burst of up to 18 bytes. After reset the channel
// valid memory is cleared entry by entry, with in_ready low. An accepted item is
// registered in the record-read stage and then in the serializer, which offers its
// first byte. The serializer sends one byte per cycle while out_ready is high and
// takes the next burst on the cycle of its last byte, so body items flow back to back
// and a longer burst holds the input until its last byte is taken. Channel records sit
// in a synchronous memory read as the item enters the read stage; a start on the
// channel written at the edge it entered the read stage uses the forwarded record.
module rtmp_chunk_stream_encoder
  import rtmp_cse_pkg::*;
#(
  parameter int CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [9:0]  csid,
  input  logic [31:0] timestamp,
  input  logic [7:0]  type_id,
  input  logic [31:0] stream_id,
  input  logic [23:0] msg_size,
  input  logic [7:0]  body_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        chunk_end,
  output logic        message_end,
  output logic        run_last
);

  localparam int CW = $clog2(CHANNELS);

  logic [23:0] max_chunk;
  chan_rec_t   mem [CHANNELS];
  logic        vmem [CHANNELS];
  logic        clr;
  logic [CW-1:0] clr_idx;

  // stage 1: item latched while record is read
  logic        s1_v;
  logic        s1_op;
  logic [9:0]  s1_id;
  logic [31:0] s1_ts, s1_sid;
  logic [7:0]  s1_ty, s1_bb;
  logic [23:0] s1_sz;
  logic [CW-1:0] s1_ch;
  logic        s1_cv;
  chan_rec_t   rd_rec;

  // last written record for forwarding
  logic        fw_v;
  logic [CW-1:0] fw_ch;
  chan_rec_t   fw_rec;

  logic [9:0]  cur_csid;
  logic [23:0] bytes_left, bytes_in_chunk;

  logic        ser_ready;
  burst_t      bst;
  logic        bst_v;
  logic        s1_adv;
  logic [CW-1:0] in_ch;
  chan_rec_t   rec, wr_rec;
  logic [31:0] delta, tsf;
  logic [1:0]  form;
  logic [23:0] lim, bic, bl;
  logic        cv;

  // id is below 1024, so four compare-subtract steps reduce it while CHANNELS is at least 64
  function automatic logic [CW-1:0] chan_of(input logic [9:0] id);
    logic [20:0] w;
    w = 21'(id);
    for (int k = 3; k >= 0; k--) begin
      if (w >= (21'(CHANNELS) << k)) w = w - (21'(CHANNELS) << k);
    end
    chan_of = w[CW-1:0];
  endfunction

  assign in_ch   = chan_of(csid);
  assign s1_adv  = !s1_v || ser_ready || !bst_v;
  assign in_ready = s1_adv && !clr;

  always_comb begin
    rec = (fw_v && fw_ch == s1_ch) ? fw_rec : rd_rec;
    cv  = s1_cv || (fw_v && fw_ch == s1_ch);
    delta = s1_ts - rec.timestamp;
    form = FORM_0;
    if (cv) begin
      if (s1_sid == rec.stream_id) begin
        if (s1_ty == rec.type_id && s1_sz == rec.size)
          form = (delta == rec.delta) ? FORM_3 : FORM_2;
        else
          form = FORM_1;
      end
    end else begin
      delta = 32'd0;
    end
    tsf = (form == FORM_0) ? s1_ts : delta;
    wr_rec.stream_id = s1_sid;
    wr_rec.type_id   = s1_ty;
    wr_rec.size      = s1_sz;
    wr_rec.timestamp = s1_ts;
    wr_rec.delta     = tsf;

    lim = (max_chunk == 24'd0) ? 24'd1 : max_chunk;
    bic = bytes_in_chunk;
    bl  = bytes_left - 24'd1;

    bst = '0;
    bst.form      = s1_op == OP_BODY ? FORM_3 : form;
    bst.csid      = s1_op == OP_BODY ? cur_csid : s1_id;
    bst.tsf       = tsf;
    bst.size      = s1_sz;
    bst.type_id   = s1_ty;
    bst.stream_id = s1_sid;
    bst.ext       = tsf >= TS_MAX;
    bst.body      = s1_op == OP_BODY;
    bst.cont      = bic >= lim;
    bst.body_byte = s1_bb;
    if (bic >= lim) bic = 24'd0;
    bic = bic + 24'd1;
    bst.message_end = (bl == 24'd0);
    bst.chunk_end   = bst.message_end || bic >= lim;
    bst_v = s1_v && (s1_op == OP_BODY ? bytes_left != 24'd0 : s1_sz != 24'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk      <= 24'd128;
      s1_v           <= 1'b0;
      fw_v           <= 1'b0;
      clr            <= 1'b1;
      clr_idx        <= '0;
      cur_csid       <= 10'd0;
      bytes_left     <= 24'd0;
      bytes_in_chunk <= 24'd0;
    end else begin
      if (cfg_we) max_chunk <= cfg_data;
      if (clr) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CW'(CHANNELS - 1)) clr <= 1'b0;
      end
      // forwarded record stays live while the item read beside it waits
      if (s1_adv) begin
        s1_v <= in_valid && !clr;
        fw_v <= s1_v && s1_op == OP_START;
      end
      if (s1_v && s1_adv) begin
        if (s1_op == OP_START) begin
          cur_csid       <= s1_id;
          bytes_left     <= s1_sz;
          bytes_in_chunk <= 24'd0;
        end else if (bytes_left != 24'd0) begin
          bytes_left     <= bl;
          bytes_in_chunk <= bst.message_end ? 24'd0 : bic;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      vmem[clr_idx] <= 1'b0;
    end else if (s1_v && s1_adv && s1_op == OP_START) begin
      vmem[s1_ch] <= 1'b1;
    end
    if (s1_v && s1_adv && s1_op == OP_START) begin
      mem[s1_ch] <= wr_rec;
      fw_rec     <= wr_rec;
      fw_ch      <= s1_ch;
    end
    if (s1_adv) begin
      rd_rec <= mem[in_ch];
      s1_cv  <= vmem[in_ch];
      s1_op  <= opcode;
      s1_id  <= csid;
      s1_ts  <= timestamp;
      s1_ty  <= type_id;
      s1_sid <= stream_id;
      s1_sz  <= msg_size;
      s1_bb  <= body_byte;
      s1_ch  <= in_ch;
    end
  end

  rtmp_cse_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (bst_v),
    .in_ready    (ser_ready),
    .in_burst    (bst),
    .valid       (out_valid),
    .ready       (out_ready),
    .out_byte    (out_byte),
    .chunk_end   (chunk_end),
    .message_end (message_end),
    .run_last    (run_last)
  );

endmodule

>>> bench/rtmp_chunk_stream_encoder_tb.sv
// Self-checking bench for the chunk stream encoder: header forms, chunking and byte order.
module rtmp_chunk_stream_encoder_tb;
  import rtmp_cse_pkg::*;

  // Expected output stream of the encoder, with its own copy of channel and chunk state.
  class chunk_scoreboard;
    typedef struct packed {
      logic [7:0] b;
      logic       ce;
      logic       me;
      logic       rl;
    } enc_byte_t;

    enc_byte_t   expected_bytes[$];
    enc_byte_t   burst[$];
    logic [23:0] max_chunk;
    bit          ch_valid[1024];
    logic [31:0] ch_sid[1024];
    logic [7:0]  ch_type[1024];
    logic [23:0] ch_size[1024];
    logic [31:0] ch_ts[1024];
    logic [31:0] ch_delta[1024];
    logic [9:0]  open_id;
    logic [23:0] left_in_msg;
    logic [23:0] in_chunk;
    int          mismatches;

    function new();
      max_chunk = 24'd128;
      foreach (ch_valid[i]) ch_valid[i] = 0;
      open_id = '0;
      left_in_msg = '0;
      in_chunk = '0;
      mismatches = 0;
    endfunction

    function void emit(logic [7:0] b, logic ce, logic me);
      enc_byte_t e;
      e.b = b;
      e.ce = ce;
      e.me = me;
      e.rl = 1'b0;
      burst.push_back(e);
    endfunction

    function void basic_hdr(logic [1:0] form, logic [9:0] id);
      logic [15:0] off;
      off = 16'(id) - 16'(ID_BASE);
      if (id > ID_TWO_MAX) begin
        emit({form, 6'd1}, 0, 0);
        emit(off[7:0], 0, 0);
        emit(off[15:8], 0, 0);
      end else if (id > ID_ONE_MAX) begin
        emit({form, 6'd0}, 0, 0);
        emit(off[7:0], 0, 0);
      end else begin
        emit({form, id[5:0]}, 0, 0);
      end
    endfunction

    function void note_input(logic op, logic [9:0] id, logic [31:0] ts, logic [7:0] ty,
                             logic [31:0] sid, logic [23:0] sz, logic [7:0] bb);
      logic [1:0]  form;
      logic [31:0] delta;
      logic [31:0] tsf;
      logic [23:0] t24;
      logic [23:0] lim;
      logic        ext;
      logic        me;
      burst.delete();
      if (op == OP_START) begin
        form = FORM_0;
        delta = '0;
        if (ch_valid[id]) begin
          delta = ts - ch_ts[id];
          if (sid == ch_sid[id]) begin
            if (ty == ch_type[id] && sz == ch_size[id])
              form = (delta == ch_delta[id]) ? FORM_3 : FORM_2;
            else
              form = FORM_1;
          end
        end
        tsf = (form == FORM_0) ? ts : delta;
        ext = tsf >= TS_MAX;
        t24 = ext ? TS_MAX[23:0] : tsf[23:0];
        if (sz != 0) begin
          basic_hdr(form, id);
          if (form != FORM_3) begin
            emit(t24[23:16], 0, 0);
            emit(t24[15:8], 0, 0);
            emit(t24[7:0], 0, 0);
          end
          if (form == FORM_0 || form == FORM_1) begin
            emit(sz[23:16], 0, 0);
            emit(sz[15:8], 0, 0);
            emit(sz[7:0], 0, 0);
            emit(ty, 0, 0);
          end
          if (form == FORM_0) begin
            emit(sid[7:0], 0, 0);
            emit(sid[15:8], 0, 0);
            emit(sid[23:16], 0, 0);
            emit(sid[31:24], 0, 0);
          end
          if (ext) begin
            emit(tsf[31:24], 0, 0);
            emit(tsf[23:16], 0, 0);
            emit(tsf[15:8], 0, 0);
            emit(tsf[7:0], 0, 0);
          end
        end
        ch_valid[id] = 1;
        ch_sid[id] = sid;
        ch_type[id] = ty;
        ch_size[id] = sz;
        ch_ts[id] = ts;
        ch_delta[id] = tsf;
        open_id = id;
        left_in_msg = sz;
        in_chunk = '0;
      end else if (left_in_msg != 0) begin
        lim = (max_chunk == 0) ? 24'd1 : max_chunk;
        if (in_chunk >= lim) begin
          basic_hdr(FORM_3, open_id);
          in_chunk = '0;
        end
        in_chunk = in_chunk + 24'd1;
        left_in_msg = left_in_msg - 24'd1;
        me = (left_in_msg == 0);
        emit(bb, me || in_chunk >= lim, me);
        if (me) in_chunk = '0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].rl = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
    endfunction

    function void check_result(logic [7:0] b, logic ce, logic me, logic rl);
      enc_byte_t e;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %h ce=%b me=%b last=%b", b, ce, me, rl);
        return;
      end
      e = expected_bytes.pop_front();
      if (e.b !== b || e.ce !== ce || e.me !== me || e.rl !== rl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: exp %h ce=%b me=%b last=%b, got %h ce=%b me=%b last=%b",
                   e.b, e.ce, e.me, e.rl, b, ce, me, rl);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        opcode = OP_BODY;
  logic [9:0]  csid = '0;
  logic [31:0] timestamp = '0;
  logic [7:0]  type_id = '0;
  logic [31:0] stream_id = '0;
  logic [23:0] msg_size = '0;
  logic [7:0]  body_byte = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_byte;
  logic        chunk_end;
  logic        message_end;
  logic        run_last;

  chunk_scoreboard sb = new();
  bit          no_idle = 0;
  bit          long_hold = 0;
  bit          hold_done = 0;
  // generator's view of each channel, used to aim at header forms 1 to 3
  bit          g_valid[1024];
  logic [31:0] g_sid[1024];
  logic [7:0]  g_type[1024];
  logic [23:0] g_size[1024];
  logic [31:0] g_ts[1024];
  logic [31:0] g_dl[1024];

  rtmp_chunk_stream_encoder u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .csid(csid),
    .timestamp(timestamp), .type_id(type_id), .stream_id(stream_id),
    .msg_size(msg_size), .body_byte(body_byte), .out_valid(out_valid),
    .out_ready(out_ready), .out_byte(out_byte), .chunk_end(chunk_end),
    .message_end(message_end), .run_last(run_last)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_input(opcode, csid, timestamp, type_id, stream_id, msg_size, body_byte);
    if (!rst && out_valid && out_ready)
      sb.check_result(out_byte, chunk_end, message_end, run_last);
  end

  // receiver: short random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2000000;
    $display("FAIL rtmp_chunk_stream_encoder");
    $finish;
  end

  task automatic send_item(logic op, logic [9:0] id, logic [31:0] ts, logic [7:0] ty,
                           logic [31:0] sid, logic [23:0] sz, logic [7:0] bb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    csid <= id;
    timestamp <= ts;
    type_id <= ty;
    stream_id <= sid;
    msg_size <= sz;
    body_byte <= bb;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_body(logic [7:0] bb);
    send_item(OP_BODY, 10'($urandom), $urandom, 8'($urandom), $urandom, 24'($urandom), bb);
  endtask

  // message start followed by n_body body bytes (n_body below sz abandons the message)
  task automatic send_message(logic [9:0] id, logic [31:0] ts, logic [7:0] ty,
                              logic [31:0] sid, logic [23:0] sz, int n_body);
    g_dl[id] = (g_valid[id] && sid == g_sid[id]) ? ts - g_ts[id] : ts;
    g_valid[id] = 1;
    g_sid[id] = sid;
    g_type[id] = ty;
    g_size[id] = sz;
    g_ts[id] = ts;
    send_item(OP_START, id, ts, ty, sid, sz, 8'($urandom));
    repeat (n_body) send_body(8'($urandom));
  endtask

  task automatic rand_message();
    logic [9:0]  id;
    logic [31:0] ts;
    logic [7:0]  ty;
    logic [31:0] sid;
    logic [23:0] sz;
    int          pick;
    int          n;
    case ($urandom_range(0, 3))
      0: id = 10'($urandom_range(2, 1023));
      1: id = 10'($urandom_range(2, 63));
      2: id = 10'($urandom_range(64, 319));
      default: id = 10'($urandom_range(320, 1023));
    endcase
    if ($urandom_range(0, 1)) id = 10'(2 + $urandom_range(0, 3));
    ts = $urandom;
    ty = 8'($urandom);
    sid = $urandom;
    sz = 24'($urandom_range(1, 10));
    if ($urandom_range(0, 9) == 0) sz = '0;
    pick = g_valid[id] ? $urandom_range(0, 4) : 0;
    case (pick)
      1: begin sid = g_sid[id]; ts = g_ts[id] + $urandom_range(0, 40); end
      2: begin
        sid = g_sid[id]; ty = g_type[id]; sz = g_size[id];
        ts = ($urandom_range(0, 3) == 0) ? g_ts[id] + 32'h00fffff0 + $urandom_range(0, 31)
                                        : g_ts[id] + $urandom_range(0, 40);
      end
      3, 4: begin sid = g_sid[id]; ty = g_type[id]; sz = g_size[id]; ts = g_ts[id] + g_dl[id]; end
      default: if ($urandom_range(0, 3) == 0) ts = 32'h00fffff0 + $urandom_range(0, 31);
    endcase
    if (sz > 24'd12) sz = 24'($urandom_range(1, 10));
    n = int'(sz);
    if (sz != 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, sz - 1);
    if ($urandom_range(0, 9) == 0) send_body(8'($urandom));
    send_message(id, ts, ty, sid, sz, n);
  endtask

  task automatic write_max_chunk(logic [23:0] v);
    in_valid <= 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.max_chunk = v;
  endtask

  initial begin
    logic [23:0] sizes[6];
    foreach (g_valid[i]) g_valid[i] = 0;
    sizes = '{24'd1, 24'd3, 24'hffffff, 24'd0, 24'd7, 24'd128};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: stray body, forms 0..3, basic header widths, extended timestamps
    send_body(8'hff);
    send_message(10'd2, 32'd0, 8'h00, 32'h0, 24'd1, 1);
    send_message(10'd2, 32'd10, 8'h00, 32'h0, 24'd1, 1);
    send_message(10'd2, 32'd20, 8'h00, 32'h0, 24'd1, 1);
    send_message(10'd2, 32'd30, 8'hff, 32'h0, 24'd2, 2);
    send_message(10'd0, 32'h00fffffe, 8'h12, 32'hffffffff, 24'd1, 1);
    send_message(10'd1, 32'h00ffffff, 8'h34, 32'h12345678, 24'd1, 1);
    send_message(10'd63, 32'hffffffff, 8'h56, 32'h0, 24'd0, 0);
    send_message(10'd64, 32'h0, 8'h01, 32'h1, 24'd1, 1);
    send_message(10'd319, 32'h5, 8'h02, 32'h2, 24'd1, 1);
    send_message(10'd320, 32'h7, 8'h03, 32'h3, 24'd1, 1);
    send_message(10'd1023, 32'h9, 8'h04, 32'h4, 24'hffffff, 2);
    send_message(10'd1023, 32'h01000010, 8'h04, 32'h4, 24'hffffff, 1);
    send_message(10'd2, 32'd40, 8'hff, 32'h0, 24'd2, 2);

    foreach (sizes[p]) begin
      write_max_chunk(sizes[p]);
      no_idle = (p == 4);
      for (int k = 0; k < 3; k++) begin
        if (p == 1 && k == 2) long_hold = 1;
        rand_message();
      end
    end
    send_message(10'd9, 32'd1, 8'd1, 32'd1, 24'd10, 10);

    in_valid <= 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
      $display("PASS rtmp_chunk_stream_encoder");
    else
      $display("FAIL rtmp_chunk_stream_encoder");
    $finish;
  end

endmodule
